FILE: rtl/mtts_pkg.sv
// mtts_pkg: shared constants, codes and controller/datapath structs
// for the multi-track tone sequencer
// no dependencies
package mtts_pkg;

    localparam int TRACKS    = 7;
    localparam int TRK_W     = 3;
    localparam int NPT       = 256;
    localparam int SLOT_W    = 8;
    localparam int ADDR_W    = TRK_W + SLOT_W;
    localparam int MEM_DEPTH = TRACKS * NPT;
    localparam int LEVEL_MAX = 2048;
    localparam int LVL_SH    = 11;
    localparam int SMP_W     = 12;
    localparam int SUM_W     = 15;
    localparam int N_W       = 3;
    localparam int CNT_W     = 9;
    localparam int POS_W     = 10;
    localparam int MS_W      = 17;
    localparam int FLD_W     = 16;
    localparam int PC_W      = 10;
    localparam int NUM_W     = 28;
    localparam int QUO_W     = 12;

    // command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_PULL  = 2'd0,
        CMD_NOTE  = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_ACT   = 2'd3
    } t_cmd;

    // wave shape codes, anything above triangle is sawtooth
    localparam logic [1:0] WAVE_SQUARE = 2'd0;
    localparam logic [1:0] WAVE_TRI    = 2'd1;

    // config register indexes
    localparam logic CFG_WAVE = 1'b0;
    localparam logic CFG_PPM  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic             take;
        logic             pull;
        logic             halt_res;
        logic             adv;
        logic             adv_rd;
        logic             adv_ld;
        logic             phase;
        logic             acc;
        logic             res_zero;
        logic             mean;
        logic             mean_done;
        logic             out_ld;
        logic [TRK_W-1:0] trk;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_pull;
        logic halted;
        logic tick;
        logic act;
        logic need_load;
        logic need_div;
        logic div_done;
        logic n_zero;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/mtts_div.sv
// mtts_div: restoring divider, twelve quotient bits, one bit per cycle
// depends on mtts_pkg; quotient must fit in twelve bits
module mtts_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mtts_pkg::NUM_W-1:0]    i_num,
    input  logic [mtts_pkg::FLD_W-1:0]    i_den,
    output logic                          o_done,
    output logic [mtts_pkg::QUO_W-1:0]    o_quo
);

    logic                         r_busy;
    logic                         r_done;
    logic [3:0]                   r_cnt;
    logic [mtts_pkg::FLD_W-1:0]   r_rem;
    logic [mtts_pkg::QUO_W-1:0]   r_low;
    logic [mtts_pkg::QUO_W-1:0]   r_quo;
    logic [mtts_pkg::FLD_W-1:0]   r_den;
    logic [mtts_pkg::FLD_W:0]     trial;
    logic                         fits;

    // shift in the next numerator bit and try a subtract
    assign trial = {r_rem, r_low[mtts_pkg::QUO_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(mtts_pkg::QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[mtts_pkg::NUM_W-1:mtts_pkg::QUO_W];
            r_low <= i_num[mtts_pkg::QUO_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? 16'(trial - {1'b0, r_den}) : trial[mtts_pkg::FLD_W-1:0];
            r_low <= {r_low[mtts_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[mtts_pkg::QUO_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/mtts_dp.sv
// mtts_dp: note memory, per-track state, mixer accumulator, config and
// output registers; depends on mtts_pkg and mtts_div
module mtts_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mtts_pkg::t_dp_cmd         i_cmd,
    output mtts_pkg::t_dp_stat        o_stat,
    input  logic [63:0]               i_s_tdata,
    input  logic [1:0]                i_s_tuser,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [15:0]               o_m_tdata,
    output logic                      o_m_tuser,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_index,
    input  logic [9:0]                i_cfg_data
);

    localparam int T = mtts_pkg::TRACKS;

    // input fields
    logic [mtts_pkg::TRK_W-1:0]  in_track;
    logic [mtts_pkg::SLOT_W-1:0] in_slot;
    logic [15:0]                 in_ms;
    logic [15:0]                 in_period;
    logic [mtts_pkg::CNT_W-1:0]  in_count;
    logic [T-1:0]                in_mask;
    mtts_pkg::t_cmd              in_cmd;

    assign in_track  = i_s_tdata[2:0];
    assign in_slot   = i_s_tdata[10:3];
    assign in_ms     = i_s_tdata[26:11];
    assign in_period = i_s_tdata[42:27];
    assign in_count  = i_s_tdata[51:43];
    assign in_mask   = i_s_tdata[58:52];
    assign in_cmd    = mtts_pkg::t_cmd'(i_s_tuser);

    // state
    logic [31:0]                  r_mem [0:mtts_pkg::MEM_DEPTH-1];
    logic [31:0]                  r_rd;
    logic [mtts_pkg::CNT_W-1:0]   r_count [T];
    logic signed [mtts_pkg::POS_W-1:0] r_pos [T];
    logic [mtts_pkg::MS_W-1:0]    r_ms [T];
    logic [mtts_pkg::FLD_W-1:0]   r_phase [T];
    logic [mtts_pkg::FLD_W-1:0]   r_period [T];
    logic [T-1:0]                 r_active;
    logic                         r_halt;
    logic [mtts_pkg::PC_W-1:0]    r_pc;
    logic [1:0]                   r_wave;
    logic [mtts_pkg::PC_W-1:0]    r_ppm;
    logic [mtts_pkg::SUM_W-1:0]   r_sum;
    logic [mtts_pkg::N_W-1:0]     r_n;
    logic [mtts_pkg::SMP_W-1:0]   r_res;
    logic                         r_ntp;
    logic                         r_ovalid;
    logic [mtts_pkg::SMP_W-1:0]   r_osmp;
    logic                         r_ontp;

    logic [mtts_pkg::TRK_W-1:0]   t;
    logic signed [mtts_pkg::POS_W-1:0] pos_nx;
    logic [mtts_pkg::PC_W-1:0]    pc_nx;
    logic [mtts_pkg::FLD_W-1:0]   p;
    logic [mtts_pkg::FLD_W:0]     h_inc;
    logic [mtts_pkg::FLD_W-1:0]   h_nx;
    logic [mtts_pkg::FLD_W:0]     h2;
    logic [mtts_pkg::FLD_W-1:0]   x;
    logic [mtts_pkg::SMP_W-1:0]   direct;
    logic                         div_start;
    logic [mtts_pkg::NUM_W-1:0]   div_num;
    logic [mtts_pkg::FLD_W-1:0]   div_den;
    logic                         div_done;
    logic [mtts_pkg::QUO_W-1:0]   div_quo;
    logic [mtts_pkg::ADDR_W-1:0]  rd_addr;
    logic                         take;

    assign t      = i_cmd.trk;
    assign take   = i_cmd.take;
    assign pos_nx = r_pos[t] + 10'sd1;
    assign pc_nx  = r_pc + 10'd1;
    assign p      = r_period[t];

    // phase step, the phase stays below the period, or at zero when the period is zero
    assign h_inc = {1'b0, r_phase[t]} + 17'd1;
    assign h_nx  = (p == '0 || h_inc == {1'b0, p}) ? '0 : h_inc[mtts_pkg::FLD_W-1:0];
    assign h2    = {h_nx, 1'b0};

    // wave numerator, scaled by the level and divided by the period
    always_comb begin
        if (r_wave == mtts_pkg::WAVE_TRI) begin
            if (h2 <= {1'b0, p})
                x = h2[mtts_pkg::FLD_W-1:0];
            else
                x = 16'({p, 1'b0} - h2);
        end else begin
            x = h_nx;
        end
    end

    // value without a division: silence or square
    assign direct = (p == '0 || h2 >= {1'b0, p}) ? '0 : 12'(mtts_pkg::LEVEL_MAX);

    // shared divider
    assign div_start = (i_cmd.phase && o_stat.need_div) || i_cmd.mean;
    assign div_num   = i_cmd.mean ? {13'd0, r_sum} : {1'b0, x, 11'd0};
    assign div_den   = i_cmd.mean ? {13'd0, r_n} : p;

    mtts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // status
    assign o_stat.in_pull   = in_cmd == mtts_pkg::CMD_PULL;
    assign o_stat.halted    = r_halt;
    assign o_stat.tick      = pc_nx >= r_ppm;
    assign o_stat.act       = r_active[t];
    assign o_stat.need_load = r_ms[t] <= 17'd1 && !pos_nx[mtts_pkg::POS_W-1]
                              && pos_nx < $signed({1'b0, r_count[t]});
    assign o_stat.need_div  = p != '0 && r_wave != mtts_pkg::WAVE_SQUARE;
    assign o_stat.div_done  = div_done;
    assign o_stat.n_zero    = r_n == '0;
    assign o_stat.out_free  = !r_ovalid || i_m_tready;

    // note memory, one write port and one registered read port
    assign rd_addr = {t, pos_nx[mtts_pkg::SLOT_W-1:0]};
    always_ff @(posedge i_clk) begin
        if (take && in_cmd == mtts_pkg::CMD_NOTE && 32'(in_track) < 32'(T))
            r_mem[{in_track, in_slot}] <= {in_period, in_ms};
        r_rd <= r_mem[rd_addr];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= mtts_pkg::WAVE_SQUARE;
            r_ppm  <= 10'd32;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mtts_pkg::CFG_WAVE)
                r_wave <= i_cfg_data[1:0];
            else
                r_ppm <= i_cfg_data;
        end
    end

    // track state, activation, note advance and phase step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < T; k++) begin
                r_count[k]  <= '0;
                r_pos[k]    <= -10'sd1;
                r_ms[k]     <= '0;
                r_phase[k]  <= '0;
                r_period[k] <= '0;
            end
            r_active <= 7'b0000111;
            r_halt   <= 1'b0;
            r_pc     <= '0;
        end else begin
            if (take && in_cmd == mtts_pkg::CMD_COUNT && 32'(in_track) < 32'(T))
                r_count[in_track] <= (in_count > 9'(mtts_pkg::NPT)) ?
                                     9'(mtts_pkg::NPT) : in_count;
            if (take && in_cmd == mtts_pkg::CMD_ACT) begin
                r_active <= in_mask;
                r_halt   <= 1'b0;
                for (int k = 0; k < T; k++) begin
                    if (in_mask[k]) begin
                        r_pos[k] <= -10'sd1;
                        r_ms[k]  <= '0;
                    end
                end
            end
            if (i_cmd.pull)
                r_pc <= o_stat.tick ? '0 : pc_nx;
            if (i_cmd.adv) begin
                if (r_ms[t] > 17'd1) begin
                    r_ms[t] <= r_ms[t] - 17'd1;
                end else begin
                    r_ms[t]  <= '0;
                    r_pos[t] <= pos_nx;
                    r_halt   <= 1'b1;
                end
            end
            if (i_cmd.adv_rd) begin
                r_ms[t]  <= '0;
                r_pos[t] <= pos_nx;
            end
            if (i_cmd.adv_ld) begin
                r_ms[t]     <= {1'b0, r_rd[15:0]};
                r_period[t] <= r_rd[31:16];
                r_phase[t]  <= '0;
            end
            if (i_cmd.phase)
                r_phase[t] <= h_nx;
        end
    end

    // mixer accumulator and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.pull) begin
            r_sum <= '0;
            r_n   <= '0;
        end
        if (i_cmd.phase) begin
            r_n <= r_n + 3'd1;
            if (!o_stat.need_div)
                r_sum <= r_sum + {3'd0, direct};
        end
        if (i_cmd.acc)
            r_sum <= r_sum + {3'd0, div_quo};
        if (i_cmd.halt_res) begin
            r_res <= '0;
            r_ntp <= 1'b1;
        end
        if (i_cmd.res_zero) begin
            r_res <= '0;
            r_ntp <= 1'b0;
        end
        if (i_cmd.mean_done) begin
            r_res <= div_quo;
            r_ntp <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_osmp <= r_res;
            r_ontp <= r_ntp;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'd0, r_osmp};
    assign o_m_tuser  = r_ontp;

endmodule

FILE: rtl/mtts_ctrl.sv
// mtts_ctrl: sequencing state machine, walks the tracks for note advance
// and mixing; depends on mtts_pkg
module mtts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  mtts_pkg::t_dp_stat  i_stat,
    output mtts_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ADV   = 8'b0000_0010,
        S_LOAD  = 8'b0000_0100,
        S_PHASE = 8'b0000_1000,
        S_WDIV  = 8'b0001_0000,
        S_MEAN  = 8'b0010_0000,
        S_MDIV  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [mtts_pkg::TRK_W-1:0]  r_trk, n_trk;
    logic                        last;

    assign last       = r_trk == 3'(mtts_pkg::TRACKS - 1);
    assign o_s_tready = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_trk   <= '0;
        end else begin
            r_state <= n_state;
            r_trk   <= n_trk;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_trk     = r_trk;
        o_cmd     = '0;
        o_cmd.trk = r_trk;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.in_pull) begin
                        if (i_stat.halted) begin
                            o_cmd.halt_res = 1'b1;
                            n_state        = S_EMIT;
                        end else begin
                            o_cmd.pull = 1'b1;
                            n_trk      = '0;
                            n_state    = i_stat.tick ? S_ADV : S_PHASE;
                        end
                    end
                end
            end
            S_ADV, S_LOAD: begin
                if (r_state == S_ADV && i_stat.act && i_stat.need_load) begin
                    o_cmd.adv_rd = 1'b1;
                    n_state      = S_LOAD;
                end else begin
                    o_cmd.adv    = r_state == S_ADV && i_stat.act;
                    o_cmd.adv_ld = r_state == S_LOAD;
                    n_trk        = last ? '0 : r_trk + 3'd1;
                    n_state      = last ? S_PHASE : S_ADV;
                end
            end
            S_PHASE: begin
                o_cmd.phase = i_stat.act;
                if (i_stat.act && i_stat.need_div) begin
                    n_state = S_WDIV;
                end else begin
                    n_trk   = last ? '0 : r_trk + 3'd1;
                    n_state = last ? S_MEAN : S_PHASE;
                end
            end
            S_WDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.acc = 1'b1;
                    n_trk     = last ? '0 : r_trk + 3'd1;
                    n_state   = last ? S_MEAN : S_PHASE;
                end
            end
            S_MEAN: begin
                if (i_stat.n_zero) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.mean = 1'b1;
                    n_state    = S_MDIV;
                end
            end
            S_MDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.mean_done = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/multi_track_tone_sequencer_unit.sv
// multi_track_tone_sequencer_unit: top level of the tone sequencer
// depends on mtts_pkg, mtts_ctrl, mtts_dp, mtts_div
//
// Seven-track tone sequencer. Note write, note count and activate words are
// taken in the idle state, and a pull while halted goes from there straight
// to the output hand-off. Any other pull is accepted; then, on a millisecond
// tick, each track in turn is stepped (a track that loads its next note reads
// it first from the note memory, whose read port is registered); then each
// track is mixed in turn, and each active track whose triangle or sawtooth
// value goes through the shared twelve-step divider waits for it; then the
// average is taken, through the divider when any track is active; and the
// result is handed to the output register once that register is free. The
// result sits in an output register, so a new word is taken while it waits.
// Note memory has no reset and needs no clearing pass; reading a note that
// was never written is undefined.
module multi_track_tone_sequencer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // track[2:0], note_slot[10:3], note_ms[26:11], note_period[42:27],
    // note_count[51:43], track_mask[58:52], zero fill above
    input  logic [63:0]  i_s_tdata,
    // cmd[1:0]
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // sample_value[11:0], zero fill above
    output logic [15:0]  o_m_tdata,
    // nothing_to_play[0]
    output logic         o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [9:0]   i_cfg_data
);

    mtts_pkg::t_dp_cmd  cmd;
    mtts_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    mtts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mtts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

FILE: rtl/mtts_chk.sv
// mtts_chk: port-level checks for the tone sequencer, bound to the top level
// depends on multi_track_tone_sequencer_unit
module mtts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // halted pull gives a zero sample
    a_halt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 16'd0)
        else $error("nonzero sample with nothing to play");

    // average never exceeds full level
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata <= 16'd2048)
        else $error("sample above full level");

endmodule

bind multi_track_tone_sequencer_unit mtts_chk u_mtts_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: tb/multi_track_tone_sequencer_unit_tb.sv
// multi_track_tone_sequencer_unit_tb: self-checking testbench for the tone sequencer
// predicts every sample word in a small scoreboard class and compares in order
// depends on mtts_pkg and multi_track_tone_sequencer_unit
`timescale 1ns / 1ps

module multi_track_tone_sequencer_unit_tb;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int SETTLE_CYCLES  = 200;

    // sample predictor and store of expected sample words
    class tone_scoreboard;
        typedef struct {
            logic [11:0] value;
            logic        silent;
        } t_sample;

        t_sample     pending[$];
        int          errors;
        bit          written[mtts_pkg::TRACKS][mtts_pkg::NPT];
        int unsigned note_ms_tab[mtts_pkg::TRACKS][mtts_pkg::NPT];
        int unsigned note_per_tab[mtts_pkg::TRACKS][mtts_pkg::NPT];
        int unsigned notes_in[mtts_pkg::TRACKS];
        int          position[mtts_pkg::TRACKS];
        int unsigned ms_left[mtts_pkg::TRACKS];
        int unsigned phase[mtts_pkg::TRACKS];
        int unsigned period[mtts_pkg::TRACKS];
        logic [6:0]  active;
        bit          halted;
        int unsigned pulls;
        int unsigned shape;
        int unsigned ppm;

        function new();
            for (int t = 0; t < mtts_pkg::TRACKS; t++) begin
                notes_in[t] = 0;
                ms_left[t]  = 0;
                phase[t]    = 0;
                period[t]   = 0;
                for (int s = 0; s < mtts_pkg::NPT; s++) written[t][s] = 0;
            end
            errors = 0;
            shape  = 0;
            ppm    = 32;
            pulls  = 0;
            restart(7'b0000111);
        endfunction

        function void set_reg(logic idx, logic [9:0] v);
            if (idx == mtts_pkg::CFG_WAVE) shape = v[1:0];
            else ppm = v;
        endfunction

        // activate: restart the selected tracks and clear the halt
        function void restart(logic [6:0] mask);
            active = mask;
            halted = 0;
            for (int t = 0; t < mtts_pkg::TRACKS; t++)
                if (mask[t]) begin
                    position[t] = -1;
                    ms_left[t]  = 0;
                end
        endfunction

        // true when the next pull would step a track onto a never written note
        function bit hits_blank(output int trk, output int slot);
            int np;
            trk  = 0;
            slot = 0;
            if (halted || ((pulls + 1) % 1024) < ppm) return 0;
            for (int t = 0; t < mtts_pkg::TRACKS; t++) begin
                np = position[t] + 1;
                if (active[t] && ms_left[t] <= 1 && np >= 0 && np < notes_in[t]
                    && !written[t][np]) begin
                    trk  = t;
                    slot = np;
                    return 1;
                end
            end
            return 0;
        endfunction

        function longint unsigned level(longint unsigned h, longint unsigned p);
            if (p == 0) return 0;
            if (shape == 0) return (2 * h < p) ? mtts_pkg::LEVEL_MAX : 0;
            if (shape == 1) begin
                if (2 * h <= p) return (2 * h * mtts_pkg::LEVEL_MAX) / p;
                return ((2 * p - 2 * h) * mtts_pkg::LEVEL_MAX) / p;
            end
            return (h * mtts_pkg::LEVEL_MAX) / p;
        endfunction

        // note an accepted input word
        function void take_word(mtts_pkg::t_cmd c, logic [63:0] d);
            int unsigned     trk, slot, cnt;
            longint unsigned sum, n;
            t_sample         e;
            trk  = d[2:0];
            slot = d[10:3];
            case (c)
                mtts_pkg::CMD_NOTE: begin
                    if (trk < mtts_pkg::TRACKS) begin
                        note_ms_tab[trk][slot]  = d[26:11];
                        note_per_tab[trk][slot] = d[42:27];
                        written[trk][slot]      = 1;
                    end
                end
                mtts_pkg::CMD_COUNT: begin
                    cnt = d[51:43];
                    if (trk < mtts_pkg::TRACKS)
                        notes_in[trk] = (cnt > mtts_pkg::NPT) ? mtts_pkg::NPT : cnt;
                end
                mtts_pkg::CMD_ACT: restart(d[58:52]);
                default: begin
                    if (halted) begin
                        e.value  = 0;
                        e.silent = 1;
                    end else begin
                        pulls = (pulls + 1) % 1024;
                        if (pulls >= ppm) begin
                            pulls = 0;
                            for (int t = 0; t < mtts_pkg::TRACKS; t++) begin
                                if (!active[t]) continue;
                                if (ms_left[t] > 1) begin
                                    ms_left[t]--;
                                    continue;
                                end
                                ms_left[t] = 0;
                                position[t]++;
                                if (position[t] < 0 || position[t] >= notes_in[t]) begin
                                    halted = 1;
                                end else begin
                                    ms_left[t] = note_ms_tab[t][position[t]];
                                    period[t]  = note_per_tab[t][position[t]];
                                    phase[t]   = 0;
                                end
                            end
                        end
                        sum = 0;
                        n   = 0;
                        for (int t = 0; t < mtts_pkg::TRACKS; t++) begin
                            if (!active[t]) continue;
                            phase[t] = (period[t] == 0) ? 0 : (phase[t] + 1) % period[t];
                            n++;
                            sum += level(phase[t], period[t]);
                        end
                        e.value  = (n == 0) ? 12'd0 : 12'((sum / n) & 12'hFFF);
                        e.silent = 0;
                    end
                    pending.push_back(e);
                end
            endcase
        endfunction

        // compare one sample word with the oldest expectation
        function void check_word(logic [15:0] data, logic silent);
            t_sample e;
            if (pending.size() == 0) begin
                $display("%0t unexpected sample word: value %0d silent %0b",
                         $time, data, silent);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data !== {4'd0, e.value}) begin
                $display("%0t sample_value mismatch: expected %0d actual %0d",
                         $time, e.value, data);
                errors++;
            end
            if (silent !== e.silent) begin
                $display("%0t nothing_to_play mismatch: expected %0b actual %0b",
                         $time, e.silent, silent);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = mtts_pkg::CMD_PULL;
    logic        m_tready = 0;
    logic        cfg_valid = 0;
    logic        cfg_index = mtts_pkg::CFG_WAVE;
    logic [9:0]  cfg_data = '0;
    wire         o_s_tready, o_m_tvalid, o_m_tuser, o_cfg_ready;
    wire  [15:0] o_m_tdata;

    tone_scoreboard sb = new();
    bit             idle_on = 1;
    int             words_sent = 0;
    int             quiet_cycles = 0;

    multi_track_tone_sequencer_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // receiver side with random stalls
    always @(posedge i_clk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 34);
    end

    // sample word checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) sb.check_word(o_m_tdata, o_m_tuser);
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)
            || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pack(int trk, int slot, int ms, int per, int cnt,
                                         int mask);
        return {5'd0, 7'(mask), 9'(cnt), 16'(per), 16'(ms), 8'(slot), 3'(trk)};
    endfunction

    task automatic send_word(mtts_pkg::t_cmd c, logic [63:0] d);
        while (idle_on && $urandom_range(99) < 34) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        s_tuser  <= c;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.take_word(c, d);
        words_sent++;
    endtask

    // a pull, or the missing note first if the pull would step onto it
    task automatic pull_sample();
        int trk, slot;
        if (sb.hits_blank(trk, slot))
            send_word(mtts_pkg::CMD_NOTE,
                      pack(trk, slot, $urandom_range(3), $urandom_range(40), 0, 0));
        else
            send_word(mtts_pkg::CMD_PULL,
                      pack($urandom_range(7), $urandom, $urandom, $urandom,
                           $urandom, $urandom));
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, v);
        cfg_valid <= 0;
    endtask

    function automatic int pick_period();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(65535);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // program a short song on a random set of tracks, start it and play it
    task automatic play_song();
        logic [6:0] mask;
        int         len, cnt;
        mask = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 127));
        for (int t = 0; t < mtts_pkg::TRACKS; t++) begin
            if (!mask[t]) continue;
            len = $urandom_range(1, 6);
            for (int s = 0; s < len; s++)
                send_word(mtts_pkg::CMD_NOTE,
                          pack(t, s, ($urandom_range(19) == 0) ? $urandom_range(65535)
                               : $urandom_range(4), pick_period(), 0, 0));
            cnt = len;
            if ($urandom_range(14) == 0) cnt = $urandom_range(511);
            send_word(mtts_pkg::CMD_COUNT,
                      pack(t, $urandom, $urandom, $urandom, cnt, $urandom));
        end
        send_word(mtts_pkg::CMD_ACT,
                  pack($urandom, $urandom, $urandom, $urandom, $urandom, mask));
        repeat ($urandom_range(20, 70)) begin
            if ($urandom_range(19) == 0)
                send_word(mtts_pkg::t_cmd'($urandom_range(1, 3)),
                          pack($urandom_range(mtts_pkg::TRACKS), $urandom_range(2),
                               $urandom, $urandom, $urandom_range(511), $urandom));
            else
                pull_sample();
        end
    endtask

    initial begin
        int phase_no;
        int ppm_pick[7] = '{1, 2, 3, 5, 0, 1023, 32};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset state, field extremes, ignored commands, halts
        pull_sample();
        send_word(mtts_pkg::CMD_NOTE, pack(0, 0, 1, 65535, 0, 0));
        send_word(mtts_pkg::CMD_NOTE, pack(6, 255, 65535, 1, 0, 0));
        send_word(mtts_pkg::CMD_NOTE, pack(7, 255, 65535, 65535, 0, 0));
        send_word(mtts_pkg::CMD_COUNT, pack(7, 0, 0, 0, 3, 0));
        send_word(mtts_pkg::CMD_COUNT, pack(3, 0, 0, 0, 511, 0));
        send_word(mtts_pkg::CMD_COUNT, pack(0, 0, 0, 0, 1, 0));
        send_word(mtts_pkg::CMD_ACT, pack(0, 0, 0, 0, 0, 7'h7F));
        repeat (3) pull_sample();
        send_word(mtts_pkg::CMD_ACT, pack(0, 0, 0, 0, 0, 0));
        pull_sample();
        send_word(mtts_pkg::CMD_ACT, pack(0, 0, 0, 0, 256, 7'h01));
        repeat (4) pull_sample();
        write_reg(mtts_pkg::CFG_PPM, 10'd1);
        write_reg(mtts_pkg::CFG_WAVE, 10'd1);
        repeat (4) pull_sample();
        write_reg(mtts_pkg::CFG_WAVE, 10'd3);
        repeat (3) pull_sample();

        // random songs under changing settings
        phase_no = 0;
        while (words_sent < 1400) begin
            idle_on = (phase_no % 6) != 3;
            if (phase_no % 3 == 0) begin
                write_reg(mtts_pkg::CFG_WAVE, 10'($urandom_range(3)));
                write_reg(mtts_pkg::CFG_PPM, 10'(ppm_pick[$urandom_range(6)]));
            end
            play_song();
            if (phase_no == 5) drain();
            phase_no++;
        end
        idle_on = 1;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
